[design/laplacian_path_smoother_macros.svh]
// Assertion helpers for the file that checks this block.
`ifndef LAPLACIAN_PATH_SMOOTHER_MACROS_SVH
`define LAPLACIAN_PATH_SMOOTHER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define LPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lps_pkg.sv]
`timescale 1ns / 1ps

package lps_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COORD_W     = 32;
    localparam int GAIN_W      = 16;
    localparam int PASS_W      = 8;
    localparam int DIFF_W      = 34;
    localparam int PROD_W      = 51;
    localparam int SUM_W       = 36;
    localparam int FRAC_W      = 16;
    localparam int DRAIN_W     = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PASSES = 2'd1;

    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd32768;
    localparam logic [PASS_W-1:0]  PASSES_RESET = 8'd10;
    localparam logic [DRAIN_W-1:0] DRAIN_LAST   = 2'd3;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = 51'sd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SMOOTH,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [PASS_W-1:0] passes;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic rd_smooth;
        logic rd_emit;
        logic last;
        logic done;
    } cmd_t;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [COORD_W-1:0] r;
        if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
            r = v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

[design/lps_cfg.sv]
`timescale 1ns / 1ps

module lps_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lps_pkg::cfg_t                    cfg
);

    logic [lps_pkg::GAIN_W-1:0] gain_reg;
    logic [lps_pkg::GAIN_W-1:0] gain_next;
    logic [lps_pkg::PASS_W-1:0] passes_reg;
    logic [lps_pkg::PASS_W-1:0] passes_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        gain_next   = gain_reg;
        passes_next = passes_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lps_pkg::CFG_GAIN:   gain_next   = cfg_data[lps_pkg::GAIN_W-1:0];
                lps_pkg::CFG_PASSES: passes_next = cfg_data[lps_pkg::PASS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= lps_pkg::GAIN_RESET;
            passes_reg <= lps_pkg::PASSES_RESET;
        end
        else
        begin
            gain_reg   <= gain_next;
            passes_reg <= passes_next;
        end
    end

    assign cfg.gain   = gain_reg;
    assign cfg.passes = passes_reg;

endmodule

[design/lps_ctrl.sv]
`timescale 1ns / 1ps

module lps_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  final_point,
    input  logic [$clog2(MAX_POINTS+1)-1:0]       count,
    input  logic [lps_pkg::PASS_W-1:0]            passes,
    output logic                                  busy,
    output lps_pkg::cmd_t                         cmd,
    output logic [$clog2(MAX_POINTS)-1:0]         rd_addr
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    lps_pkg::state_t             state_reg;
    lps_pkg::state_t             state_next;
    logic [AW-1:0]               idx_reg;
    logic [AW-1:0]               idx_next;
    logic [lps_pkg::PASS_W-1:0]  pass_reg;
    logic [lps_pkg::PASS_W-1:0]  pass_next;
    logic [lps_pkg::DRAIN_W-1:0] drain_reg;
    logic [lps_pkg::DRAIN_W-1:0] drain_next;

    logic          last_idx;
    logic          full;
    logic [CW-1:0] n_after;
    logic          smooth_go;

    assign last_idx  = (CW'(idx_reg) == (count - CW'(1)));
    assign full      = (count == CW'(MAX_POINTS));
    assign n_after   = full ? count : (count + CW'(1));
    assign smooth_go = (n_after > CW'(2)) && (passes != '0);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        drain_next = drain_reg;
        case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                if (start && final_point)
                begin
                    idx_next   = '0;
                    pass_next  = '0;
                    drain_next = '0;
                    state_next = smooth_go ? lps_pkg::ST_SMOOTH : lps_pkg::ST_EMIT;
                end
            end
            lps_pkg::ST_SMOOTH:
            begin
                if (last_idx)
                begin
                    idx_next   = '0;
                    drain_next = '0;
                    state_next = lps_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            lps_pkg::ST_DRAIN:
            begin
                if (drain_reg == lps_pkg::DRAIN_LAST)
                begin
                    drain_next = '0;
                    if (pass_reg == (passes - lps_pkg::PASS_W'(1)))
                    begin
                        pass_next  = '0;
                        state_next = lps_pkg::ST_EMIT;
                    end
                    else
                    begin
                        pass_next  = pass_reg + lps_pkg::PASS_W'(1);
                        state_next = lps_pkg::ST_SMOOTH;
                    end
                end
                else
                begin
                    drain_next = drain_reg + lps_pkg::DRAIN_W'(1);
                end
            end
            lps_pkg::ST_EMIT:
            begin
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = lps_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = lps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        rd_addr = idx_reg;
        busy    = (state_reg != lps_pkg::ST_IDLE);
        case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            lps_pkg::ST_SMOOTH:
            begin
                cmd.rd_smooth = 1'b1;
            end
            lps_pkg::ST_EMIT:
            begin
                cmd.rd_emit = 1'b1;
                cmd.last    = last_idx;
                cmd.done    = last_idx;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lps_pkg::ST_IDLE;
            idx_reg   <= '0;
            pass_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            drain_reg <= drain_next;
        end
    end

endmodule

[design/lps_datapath.sv]
`timescale 1ns / 1ps

module lps_datapath #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lps_pkg::cmd_t                         cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]         rd_addr,
    input  logic [lps_pkg::GAIN_W-1:0]            gain,
    input  logic signed [lps_pkg::COORD_W-1:0]    coord_x,
    input  logic signed [lps_pkg::COORD_W-1:0]    coord_y,
    input  logic signed [lps_pkg::COORD_W-1:0]    coord_z,
    output logic [$clog2(MAX_POINTS+1)-1:0]       count,
    output logic                                  out_valid,
    output logic signed [lps_pkg::COORD_W-1:0]    out_x,
    output logic signed [lps_pkg::COORD_W-1:0]    out_y,
    output logic signed [lps_pkg::COORD_W-1:0]    out_z,
    output logic                                  out_final,
    output logic                                  dropped_points
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int LANES = 3;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          overflow_reg;
    logic          overflow_next;
    logic          store_en;

    logic          s1_valid_reg;
    logic [AW-1:0] s1_idx_reg;
    logic          sa_valid_reg;
    logic          sa_valid_next;
    logic [AW-1:0] sa_idx_reg;
    logic          sb_valid_reg;
    logic [AW-1:0] sb_idx_reg;

    logic          out_valid_reg;
    logic          out_final_reg;
    logic          dropped_reg;

    logic [LANES-1:0][lps_pkg::COORD_W-1:0] coord_in;
    logic [LANES-1:0][lps_pkg::COORD_W-1:0] lane_rdata;

    assign coord_in[0] = coord_x;
    assign coord_in[1] = coord_y;
    assign coord_in[2] = coord_z;

    assign store_en      = cmd.load && (count_reg < CW'(MAX_POINTS));
    assign sa_valid_next = s1_valid_reg && (s1_idx_reg >= AW'(2));

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (cmd.done)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end
        else if (cmd.load)
        begin
            if (store_en)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            sa_valid_reg  <= 1'b0;
            sb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            s1_valid_reg  <= cmd.rd_smooth;
            sa_valid_reg  <= sa_valid_next;
            sb_valid_reg  <= sa_valid_reg;
            out_valid_reg <= cmd.rd_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg    <= rd_addr;
        sa_idx_reg    <= s1_idx_reg - AW'(1);
        sb_idx_reg    <= sa_idx_reg;
        out_final_reg <= cmd.last;
        dropped_reg   <= overflow_reg;
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [lps_pkg::COORD_W-1:0]        mem [MAX_POINTS];
        logic [lps_pkg::COORD_W-1:0]        rdata_reg;
        logic [lps_pkg::COORD_W-1:0]        w0_reg;
        logic [lps_pkg::COORD_W-1:0]        w1_reg;
        logic signed [lps_pkg::DIFF_W-1:0]  d_reg;
        logic signed [lps_pkg::DIFF_W-1:0]  d_next;
        logic [lps_pkg::COORD_W-1:0]        cura_reg;
        logic signed [lps_pkg::PROD_W-1:0]  p_reg;
        logic signed [lps_pkg::PROD_W-1:0]  p_next;
        logic [lps_pkg::COORD_W-1:0]        curb_reg;
        logic signed [lps_pkg::GAIN_W:0]    gain_s;
        logic signed [lps_pkg::SUM_W-1:0]   sum;
        logic                               wr_en;
        logic [AW-1:0]                      wr_addr;
        logic [lps_pkg::COORD_W-1:0]        wr_data;

        assign d_next = $signed({{2{w0_reg[31]}}, w0_reg})
                      + $signed({{2{rdata_reg[31]}}, rdata_reg})
                      - $signed({w1_reg[31], w1_reg, 1'b0});
        assign gain_s = $signed({1'b0, gain});
        assign p_next = gain_s * d_reg + lps_pkg::ROUND_HALF;
        assign sum    = $signed({{4{curb_reg[31]}}, curb_reg})
                      + $signed({p_reg[lps_pkg::PROD_W-1],
                                 p_reg[lps_pkg::PROD_W-1:lps_pkg::FRAC_W]});

        always_comb
        begin
            wr_en   = store_en || sb_valid_reg;
            wr_addr = sb_idx_reg;
            wr_data = lps_pkg::sat32(sum);
            if (store_en)
            begin
                wr_addr = count_reg[AW-1:0];
                wr_data = coord_in[l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_addr] <= wr_data;
            end
            rdata_reg <= mem[rd_addr];
        end

        always_ff @(posedge clk)
        begin
            if (s1_valid_reg)
            begin
                w0_reg <= w1_reg;
                w1_reg <= rdata_reg;
            end
            d_reg    <= d_next;
            cura_reg <= w1_reg;
            p_reg    <= p_next;
            curb_reg <= cura_reg;
        end

        assign lane_rdata[l] = rdata_reg;
    end

    assign count          = count_reg;
    assign out_valid      = out_valid_reg;
    assign out_x          = lane_rdata[0];
    assign out_y          = lane_rdata[1];
    assign out_z          = lane_rdata[2];
    assign out_final      = out_final_reg;
    assign dropped_points = dropped_reg;

endmodule

[design/laplacian_path_smoother.sv]
// Loading takes one point per cycle while idle; busy stays low until the final point is transferred.
// For N > 2 points and P > 0 passes, each pass walks the store once and then waits in the drain state.
// After the last pass the results are emitted, one per cycle.
// Otherwise the path is replayed unchanged, straight from the idle state.
// Reset clears control state, gain to 32768 and passes to 10; the point store is not cleared.
`timescale 1ns / 1ps
`include "laplacian_path_smoother_macros.svh"

module laplacian_path_smoother #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [lps_pkg::COORD_W-1:0]    coord_x,
    input  logic signed [lps_pkg::COORD_W-1:0]    coord_y,
    input  logic signed [lps_pkg::COORD_W-1:0]    coord_z,
    input  logic                                  final_point,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lps_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  out_valid,
    output logic signed [lps_pkg::COORD_W-1:0]    out_x,
    output logic signed [lps_pkg::COORD_W-1:0]    out_y,
    output logic signed [lps_pkg::COORD_W-1:0]    out_z,
    output logic                                  out_final,
    output logic                                  dropped_points
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    lps_pkg::cfg_t cfg;
    lps_pkg::cmd_t cmd;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] count;

    lps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lps_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .final_point (final_point),
        .count       (count),
        .passes      (cfg.passes),
        .busy        (busy),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    lps_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .gain           (cfg.gain),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .coord_z        (coord_z),
        .count          (count),
        .out_valid      (out_valid),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .out_final      (out_final),
        .dropped_points (dropped_points)
    );

    `LPS_ASSERT_SAME(a_result_while_busy, out_valid, $past(busy), "Result transfer without a busy cycle before it")
    `LPS_ASSERT_NEXT(a_final_ends_burst, out_valid && out_final, !out_valid, "Result transfer right after the last point")
    `LPS_ASSERT_NEXT(a_burst_contiguous, out_valid && !out_final, out_valid, "Gap inside a result burst")
    `LPS_ASSERT_NEXT(a_final_sets_busy, start && !busy && final_point, busy, "Final point transfer did not raise busy")

endmodule
